/* sv/ctcu_pkg.sv */
// ----------------------------------------------------------------------------
// ctcu_pkg
// Types, codes and constants shared by the clock time conversion unit.
// ----------------------------------------------------------------------------
package ctcu_pkg;

   localparam int TIME_W      = 64;
   localparam int SCALE_W     = 30;
   localparam int PROD_W      = 62;
   localparam int ACC_W       = 96;
   localparam int CSR_INDEX_W = 4;

   localparam logic [SCALE_W-1:0] NS_PER_S  = 30'd1000000000;
   localparam logic [SCALE_W-1:0] NS_PER_US = 30'd1000;

   localparam logic [TIME_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [TIME_W-1:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [TIME_W-1:0] SMIN     = 64'h8000_0000_0000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_READY   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_FREQ_HZ = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_BASE    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_UPTIME_US  = 4'd3;

   localparam logic CMD_READ = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   localparam logic [2:0] CLK_REALTIME      = 3'd0;
   localparam logic [2:0] CLK_MONOTONIC     = 3'd1;
   localparam logic [2:0] CLK_MONOTONIC_RAW = 3'd2;
   localparam logic [2:0] CLK_BOOT_TIME     = 3'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA_MUL,
      ST_DIV,
      ST_BASE_MUL,
      ST_UP_MUL,
      ST_APPLY,
      ST_RTC_MUL,
      ST_REAL,
      ST_RESULT
   } ctcu_state_type;

   typedef enum logic [1:0] {
      MAC_IDLE,
      MAC_LO,
      MAC_HI,
      MAC_ACC
   } mac_step_type;

   typedef struct packed {
      logic start;
      logic scale_ns;
   } mac_ctl_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

/* sv/ctcu_if.sv */
// ----------------------------------------------------------------------------
// ctcu_if
// Valid/ready channels of the clock time conversion unit.
// ----------------------------------------------------------------------------
interface ctcu_req_if import ctcu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [2:0]        clock_sel;
   logic [TIME_W-1:0] counter_now;
   logic [TIME_W-1:0] tick_uptime_us;
   logic [TIME_W-1:0] rtc_seconds;
   logic [TIME_W-1:0] new_time_ns;

   modport source (output valid, cmd, clock_sel, counter_now, tick_uptime_us,
                   rtc_seconds, new_time_ns, input ready);
   modport sink   (input valid, cmd, clock_sel, counter_now, tick_uptime_us,
                   rtc_seconds, new_time_ns, output ready);
endinterface

interface ctcu_rsp_if import ctcu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_ns;
   logic              status;

   modport source (output valid, time_ns, status, input ready);
   modport sink   (input valid, time_ns, status, output ready);
endinterface

interface ctcu_csr_if import ctcu_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [TIME_W-1:0]      wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* sv/ctcu_mac.sv */
// ----------------------------------------------------------------------------
// ctcu_mac
// Shared multiplier: 64-bit operand times 1e9 or 1000, as two 32-bit partial
// products accumulated into a 96-bit result.
// ----------------------------------------------------------------------------
module ctcu_mac import ctcu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mac_ctl_type       ctl,
   input  logic [TIME_W-1:0] operand,
   output unit_sts_type      sts,
   output logic [ACC_W-1:0]  product
);

   mac_step_type      step_ff, step_in;
   logic              done_ff, done_in;
   logic [TIME_W-1:0] opnd_ff, opnd_in;
   logic              scale_ff, scale_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   logic [31:0]        chunk;
   logic [SCALE_W-1:0] factor;

   assign chunk  = (step_ff == MAC_LO) ? opnd_ff[31:0] : opnd_ff[63:32];
   assign factor = scale_ff ? NS_PER_S : NS_PER_US;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= MAC_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      opnd_ff  <= opnd_in;
      scale_ff <= scale_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   always_comb begin
      step_in  = step_ff;
      done_in  = 1'b0;
      opnd_in  = opnd_ff;
      scale_in = scale_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      unique case (step_ff)
         MAC_IDLE: begin
            if (ctl.start) begin
               opnd_in  = operand;
               scale_in = ctl.scale_ns;
               step_in  = MAC_LO;
            end
         end
         MAC_LO: begin
            prod_in = PROD_W'(chunk) * PROD_W'(factor);
            step_in = MAC_HI;
         end
         MAC_HI: begin
            acc_in  = {{(ACC_W-PROD_W){1'b0}}, prod_ff};
            prod_in = PROD_W'(chunk) * PROD_W'(factor);
            step_in = MAC_ACC;
         end
         MAC_ACC: begin
            acc_in  = acc_ff + {{(ACC_W-PROD_W-32){1'b0}}, prod_ff, 32'd0};
            done_in = 1'b1;
            step_in = MAC_IDLE;
         end
         default: step_in = MAC_IDLE;
      endcase
   end

   assign sts.busy = (step_ff != MAC_IDLE);
   assign sts.done = done_ff;
   assign product  = acc_ff;

endmodule

/* sv/ctcu_div.sv */
// ----------------------------------------------------------------------------
// ctcu_div
// Radix-2 restoring divider: 128-bit dividend by 64-bit divisor, one
// quotient bit per cycle. The upper dividend half must be below the divisor.
// ----------------------------------------------------------------------------
module ctcu_div import ctcu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [TIME_W-1:0] dividend_hi,
   input  logic [TIME_W-1:0] dividend_lo,
   input  logic [TIME_W-1:0] divisor,
   output unit_sts_type      sts,
   output logic [TIME_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [5:0]        count_ff, count_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0] dvsr_ff, dvsr_in;

   logic [TIME_W:0] shifted;
   logic [TIME_W:0] trial;
   logic            fits;

   // remainder shifted left with the next dividend bit; quotient bits fill
   // the low end of the same shift register
   assign shifted = {rem_ff, quo_ff[TIME_W-1]};
   assign trial   = shifted - {1'b0, dvsr_ff};
   assign fits    = ~trial[TIME_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvsr_in  = dvsr_ff;
      if (busy_ff) begin
         rem_in   = fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
         quo_in   = {quo_ff[TIME_W-2:0], fits};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         rem_in   = dividend_hi;
         quo_in   = dividend_lo;
         dvsr_in  = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/clock_time_conversion_unit.sv */
// ----------------------------------------------------------------------------
// clock_time_conversion_unit
// Reads realtime, monotonic, monotonic raw and boot time clocks in
// nanoseconds and sets realtime. Monotonic time is base_uptime_us*1000 plus
// (counter_now - counter_base)*1e9/counter_freq_hz when the counter is
// calibrated, else tick_uptime_us*1000, all saturating. Realtime adds a
// signed offset that is seeded from rtc_seconds*1e9 on first use. One item is
// in flight at a time. On the counter path an item runs the shared
// multiplier on the counter delta, then the 64-step divider, then the
// multiplier on base_uptime_us; when the counter result is zero the tick
// fallback multiplies tick_uptime_us as well. When the quotient cannot fit
// in 64 bits the divider is skipped. The tick path runs the multiplier once,
// and a realtime read that seeds the offset adds one more multiplication.
// A finished result waits in the output register while the next request is
// taken; a second finished result stalls until that register frees. The
// configuration port is always ready.
// ----------------------------------------------------------------------------
module clock_time_conversion_unit import ctcu_pkg::*; (
   input logic        clock,
   input logic        reset,
   ctcu_req_if.sink   req_if,
   ctcu_rsp_if.source rsp_if,
   ctcu_csr_if.sink   csr_if
);

   // configuration
   logic              counter_ready_ff;
   logic [TIME_W-1:0] counter_freq_hz_ff;
   logic [TIME_W-1:0] counter_base_ff;
   logic [TIME_W-1:0] base_uptime_us_ff;

   ctcu_state_type    state_ff, state_in;
   logic              cmd_ff, cmd_in;
   logic [2:0]        sel_ff, sel_in;
   logic [TIME_W-1:0] uptime_ff, uptime_in;
   logic [TIME_W-1:0] rtc_ff, rtc_in;
   logic [TIME_W-1:0] newtime_ff, newtime_in;
   logic [TIME_W-1:0] q_ff, q_in;
   logic [TIME_W-1:0] mono_ff, mono_in;
   logic [TIME_W-1:0] res_time_ff, res_time_in;
   logic              res_status_ff, res_status_in;
   logic [TIME_W-1:0] offset_ff, offset_in;
   logic              offset_valid_ff, offset_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic              rsp_status_ff, rsp_status_in;

   mac_ctl_type       mac_ctl;
   unit_sts_type      mac_sts;
   logic [TIME_W-1:0] mac_operand;
   logic [ACC_W-1:0]  mac_product;
   div_ctl_type       div_ctl;
   unit_sts_type      div_sts;
   logic [TIME_W-1:0] div_quotient;

   logic              ctr_ok;
   logic [TIME_W:0]   delta_diff;
   logic [TIME_W-1:0] delta;
   logic [TIME_W-1:0] mac_sat;
   logic [TIME_W-1:0] div_hi;
   logic              hi_ovf;
   logic [TIME_W:0]   base_sum;
   logic [TIME_W-1:0] base_mono;
   logic [TIME_W:0]   set_diff;
   logic              set_err;
   logic [TIME_W:0]   seed_diff;
   logic [TIME_W-1:0] seed_off;
   logic [TIME_W+1:0] real_sum;
   logic [TIME_W-1:0] real_time;

   ctcu_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .operand (mac_operand),
      .sts     (mac_sts),
      .product (mac_product)
   );

   ctcu_div u_div (
      .clock       (clock),
      .reset       (reset),
      .ctl         (div_ctl),
      .dividend_hi (div_hi),
      .dividend_lo (mac_product[TIME_W-1:0]),
      .divisor     (counter_freq_hz_ff),
      .sts         (div_sts),
      .quotient    (div_quotient)
   );

   // configuration writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ready_ff   <= 1'b0;
         counter_freq_hz_ff <= '0;
         counter_base_ff    <= '0;
         base_uptime_us_ff  <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_COUNTER_READY:   counter_ready_ff   <= csr_if.wdata[0];
            CSR_COUNTER_FREQ_HZ: counter_freq_hz_ff <= csr_if.wdata;
            CSR_COUNTER_BASE:    counter_base_ff    <= csr_if.wdata;
            CSR_BASE_UPTIME_US:  base_uptime_us_ff  <= csr_if.wdata;
            default: ;
         endcase
      end
   end

   // datapath helpers
   assign ctr_ok     = counter_ready_ff && (counter_freq_hz_ff != '0);
   assign delta_diff = {1'b0, req_if.counter_now} - {1'b0, counter_base_ff};
   assign delta      = delta_diff[TIME_W] ? '0 : delta_diff[TIME_W-1:0];

   assign mac_sat = (|mac_product[ACC_W-1:TIME_W]) ? ALL_ONES : mac_product[TIME_W-1:0];
   assign div_hi  = {{(2*TIME_W-ACC_W){1'b0}}, mac_product[ACC_W-1:TIME_W]};
   assign hi_ovf  = (div_hi >= counter_freq_hz_ff);

   assign base_sum  = {1'b0, mac_sat} + {1'b0, q_ff};
   assign base_mono = base_sum[TIME_W] ? ALL_ONES : base_sum[TIME_W-1:0];

   // offset = new - mono; out of signed range when borrow and sign disagree,
   // and the most negative value is rejected too
   assign set_diff = {1'b0, newtime_ff} - {1'b0, mono_ff};
   assign set_err  = (set_diff[TIME_W] != set_diff[TIME_W-1]) ||
                     (set_diff[TIME_W] && (set_diff[TIME_W-1:0] == SMIN));

   assign seed_diff = {1'b0, mac_sat} - {1'b0, mono_ff};
   assign seed_off  = (seed_diff[TIME_W] != seed_diff[TIME_W-1]) ?
                      (seed_diff[TIME_W] ? SMIN : SMAX) : seed_diff[TIME_W-1:0];

   assign real_sum  = {2'b00, mono_ff} + {{2{offset_ff[TIME_W-1]}}, offset_ff};
   assign real_time = real_sum[TIME_W+1] ? '0 :
                      (real_sum[TIME_W] ? ALL_ONES : real_sum[TIME_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         offset_ff       <= '0;
         offset_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         offset_ff       <= offset_in;
         offset_valid_ff <= offset_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      sel_ff        <= sel_in;
      uptime_ff     <= uptime_in;
      rtc_ff        <= rtc_in;
      newtime_ff    <= newtime_in;
      q_ff          <= q_in;
      mono_ff       <= mono_in;
      res_time_ff   <= res_time_in;
      res_status_ff <= res_status_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      sel_in           = sel_ff;
      uptime_in        = uptime_ff;
      rtc_in           = rtc_ff;
      newtime_in       = newtime_ff;
      q_in             = q_ff;
      mono_in          = mono_ff;
      res_time_in      = res_time_ff;
      res_status_in    = res_status_ff;
      offset_in        = offset_ff;
      offset_valid_in  = offset_valid_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_time_in      = rsp_time_ff;
      rsp_status_in    = rsp_status_ff;
      mac_ctl.start    = 1'b0;
      mac_ctl.scale_ns = 1'b0;
      mac_operand      = uptime_ff;
      div_ctl.start    = 1'b0;
      req_if.ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               cmd_in        = req_if.cmd;
               sel_in        = req_if.clock_sel;
               uptime_in     = req_if.tick_uptime_us;
               rtc_in        = req_if.rtc_seconds;
               newtime_in    = req_if.new_time_ns;
               mac_ctl.start = 1'b1;
               if (ctr_ok) begin
                  mac_operand      = delta;
                  mac_ctl.scale_ns = 1'b1;
                  state_in         = ST_DELTA_MUL;
               end else begin
                  mac_operand = req_if.tick_uptime_us;
                  state_in    = ST_UP_MUL;
               end
            end
         end
         ST_DELTA_MUL: begin
            if (mac_sts.done) begin
               if (hi_ovf) begin
                  // quotient would not fit in 64 bits
                  q_in          = ALL_ONES;
                  mac_ctl.start = 1'b1;
                  mac_operand   = base_uptime_us_ff;
                  state_in      = ST_BASE_MUL;
               end else begin
                  div_ctl.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               q_in          = div_quotient;
               mac_ctl.start = 1'b1;
               mac_operand   = base_uptime_us_ff;
               state_in      = ST_BASE_MUL;
            end
         end
         ST_BASE_MUL: begin
            if (mac_sts.done) begin
               if (base_mono != '0) begin
                  mono_in  = base_mono;
                  state_in = ST_APPLY;
               end else begin
                  // zero counter time falls back to tick uptime
                  mac_ctl.start = 1'b1;
                  mac_operand   = uptime_ff;
                  state_in      = ST_UP_MUL;
               end
            end
         end
         ST_UP_MUL: begin
            if (mac_sts.done) begin
               mono_in  = mac_sat;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            res_time_in   = '0;
            res_status_in = STATUS_OK;
            state_in      = ST_RESULT;
            if (cmd_ff == CMD_SET) begin
               if (set_err) begin
                  res_status_in = STATUS_ERR;
               end else begin
                  offset_in       = set_diff[TIME_W-1:0];
                  offset_valid_in = 1'b1;
               end
            end else if (sel_ff == CLK_REALTIME) begin
               if (offset_valid_ff) begin
                  state_in = ST_REAL;
               end else begin
                  mac_ctl.start    = 1'b1;
                  mac_ctl.scale_ns = 1'b1;
                  mac_operand      = rtc_ff;
                  state_in         = ST_RTC_MUL;
               end
            end else if ((sel_ff == CLK_MONOTONIC) || (sel_ff == CLK_MONOTONIC_RAW) ||
                         (sel_ff == CLK_BOOT_TIME)) begin
               res_time_in = mono_ff;
            end else begin
               res_status_in = STATUS_ERR;
            end
         end
         ST_RTC_MUL: begin
            if (mac_sts.done) begin
               offset_in       = seed_off;
               offset_valid_in = 1'b1;
               state_in        = ST_REAL;
            end
         end
         ST_REAL: begin
            res_time_in   = real_time;
            res_status_in = STATUS_OK;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_time_in   = res_time_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.time_ns = rsp_time_ff;
   assign rsp_if.status  = rsp_status_ff;

`ifndef SYNTHESIS
   a_mac_start_idle: assert property (@(posedge clock) disable iff (reset)
      mac_ctl.start |-> !mac_sts.busy)
      else $error("multiplier started while busy");

   a_div_start_range: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> (!div_sts.busy && (div_hi < counter_freq_hz_ff)))
      else $error("divider started while busy or with overflowing dividend");

   a_set_err_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && cmd_ff == CMD_SET && set_err)
      |=> ($stable(offset_ff) && $stable(offset_valid_ff)))
      else $error("rejected set changed the realtime offset");

   a_real_seeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REAL) |-> offset_valid_ff)
      else $error("realtime computed from an unseeded offset");
`endif

endmodule
